>>> design/cell_averaging_cfar_2d_unit_macros.svh
`ifndef CELL_AVERAGING_CFAR_2D_UNIT_MACROS_SVH
`define CELL_AVERAGING_CFAR_2D_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CACF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cacf check failed");

// next-cycle implication, checked outside reset
`define CACF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cacf check failed");

`endif

>>> design/cacf_pkg.sv
`default_nettype none
package cacf_pkg;

  localparam int CFG_W     = 24;
  localparam int SIZE_W    = 11;
  localparam int WIN_W     = 4;
  localparam int SCALE_W   = 24;
  localparam int POWER_W   = 24;
  localparam int POS_W     = 10;
  localparam int SUM_OUT_W = 33;
  localparam int FRAC_BITS = 16;

  localparam logic [SIZE_W-1:0]  RST_FRAME_ROWS = 11'd1024;
  localparam logic [SIZE_W-1:0]  RST_FRAME_COLS = 11'd1024;
  localparam logic [WIN_W-1:0]   RST_REF        = 4'd4;
  localparam logic [WIN_W-1:0]   RST_GUARD      = 4'd1;
  localparam logic [SCALE_W-1:0] RST_SCALE      = 24'd262144;

  typedef enum logic [2:0] {
    REG_FRAME_ROWS,
    REG_FRAME_COLS,
    REG_REF_ROWS,
    REG_GUARD_ROWS,
    REG_REF_COLS,
    REG_GUARD_COLS,
    REG_SCALE
  } cacf_reg_t;

  // clamped window extents
  typedef struct packed {
    logic [4:0] wr;
    logic [4:0] gr;
    logic [4:0] wc;
    logic [4:0] gc;
  } cacf_win_t;

  typedef struct packed {
    logic vld;
    logic res;
    logic last;
  } cacf_flag_t;

  typedef struct packed {
    logic                 detected;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [SUM_OUT_W-1:0] ref_sum;
    logic                 last;
  } cacf_res_t;

endpackage
`default_nettype wire

>>> design/cacf_cell.sv
`default_nettype none
module cacf_cell #(
  parameter int OW = 30,
  parameter int SB = 24
) (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire logic [OW-1:0] in_outer,
  input  wire logic [OW-1:0] in_guard,
  input  wire logic [SB-1:0] in_center,
  output logic      [OW-1:0] outer,
  output logic      [OW-1:0] guard,
  output logic      [SB-1:0] center
);

  logic [OW-1:0] outer_r;
  logic [OW-1:0] guard_r;
  logic [SB-1:0] center_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      outer_r  <= in_outer;
      guard_r  <= in_guard;
      center_r <= in_center;
    end
  end

  assign outer  = outer_r;
  assign guard  = guard_r;
  assign center = center_r;

endmodule
`default_nettype wire

>>> design/cacf_colsum.sv
`default_nettype none
module cacf_colsum import cacf_pkg::*; #(
  parameter int LINES = 17,
  parameter int DEPTH = 1024,
  parameter int SB    = 24,
  parameter int BW    = 5,
  parameter int CW    = 10,
  parameter int OW    = 30
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic          wr_en,
  input  wire logic [BW-1:0] bank,
  input  wire logic [CW-1:0] addr,
  input  wire logic [SB-1:0] din,
  input  wire cacf_win_t     win,
  output logic      [OW-1:0] col_outer,
  output logic      [OW-1:0] col_guard,
  output logic      [SB-1:0] col_center
);

  localparam int GS = 6;
  localparam int NG = (LINES + GS - 1) / GS;
  localparam int GW = SB + 3;

  logic [SB-1:0] rd_r [LINES];
  logic [SB-1:0] din_r;
  logic [BW-1:0] bank_r;
  logic [SB-1:0] v [LINES];
  logic [BW-1:0] idx;
  logic [GW-1:0] go [NG];
  logic [GW-1:0] gg [NG];
  logic [GW-1:0] go_r [NG];
  logic [GW-1:0] gg_r [NG];
  logic [SB-1:0] ctr_r;
  logic [OW-1:0] so;
  logic [OW-1:0] sg;
  logic [OW-1:0] col_outer_r;
  logic [OW-1:0] col_guard_r;
  logic [SB-1:0] col_center_r;

  for (genvar b = 0; b < LINES; b++) begin : g_bank
    logic [SB-1:0] bank_mem [DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en && bank == BW'(b)) begin
        bank_mem[addr] <= din;
      end
      if (adv) begin
        rd_r[b] <= bank_mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      din_r  <= din;
      bank_r <= bank;
    end
  end

  // k rows back from the current row
  always_comb begin
    idx = '0;
    for (int k = 0; k < LINES; k++) begin
      if (k == 0) begin
        v[k] = din_r;
      end else begin
        if (bank_r >= BW'(k)) begin
          idx = bank_r - BW'(k);
        end else begin
          idx = BW'(int'(bank_r) + LINES - k);
        end
        v[k] = rd_r[idx];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      go[g] = '0;
      gg[g] = '0;
      for (int j = 0; j < GS; j++) begin
        if (g * GS + j < LINES) begin
          if (6'(g * GS + j) <= {win.wr, 1'b0}) begin
            go[g] = go[g] + GW'(v[g * GS + j]);
          end
          if ((6'(g * GS + j) + 6'(win.gr) >= 6'(win.wr)) &&
              (6'(g * GS + j) <= 6'(win.wr) + 6'(win.gr))) begin
            gg[g] = gg[g] + GW'(v[g * GS + j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      go_r  <= go;
      gg_r  <= gg;
      ctr_r <= v[BW'(win.wr)];
    end
  end

  always_comb begin
    so = '0;
    sg = '0;
    for (int g = 0; g < NG; g++) begin
      so = so + OW'(go_r[g]);
      sg = sg + OW'(gg_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_outer_r  <= so;
      col_guard_r  <= sg;
      col_center_r <= ctr_r;
    end
  end

  assign col_outer  = col_outer_r;
  assign col_guard  = col_guard_r;
  assign col_center = col_center_r;

endmodule
`default_nettype wire

>>> design/cell_averaging_cfar_2d_unit.sv
// channel   ports                                      direction
// input     in_valid, in_stall, in_power,              into block
//           in_first_of_frame
// result    out_valid, out_stall, out_detected,        out of block
//           out_cell_row, out_cell_col, out_ref_sum,
//           out_last_of_frame
// config    cfg_wr_en, cfg_index, cfg_data             into block
//
// one cell per clock unless in_stall; a result follows the cell that completes its window
// throughput set by the per-row line banks (one write, one read per cycle) and the column chain
// reset clears position, pipeline valids, output and skid; line banks are not cleared
// a stalled result is held in the output register, one more fits in the skid stage
// in_stall rises only while the skid stage is full
`default_nettype none
module cell_averaging_cfar_2d_unit import cacf_pkg::*; #(
  parameter int MAX_ROWS        = 1024,
  parameter int MAX_COLS        = 1024,
  parameter int MAX_HALF_WINDOW = 8,
  parameter int SAMPLE_BITS     = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [POWER_W-1:0]   in_power,
  input  wire logic                 in_first_of_frame,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_detected,
  output logic [POS_W-1:0]          out_cell_row,
  output logic [POS_W-1:0]          out_cell_col,
  output logic [SUM_OUT_W-1:0]      out_ref_sum,
  output logic                      out_last_of_frame,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int H     = MAX_HALF_WINDOW;
  localparam int LINES = 2 * H + 1;
  localparam int BW    = $clog2(LINES);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int SB    = SAMPLE_BITS;
  localparam int OW    = SB + 6;
  localparam int SW    = SB + 12;
  localparam int SH    = SW / 2;
  localparam int PW    = SCALE_W + SW;
  localparam int NST   = 6;

  // configuration
  logic [SIZE_W-1:0]  frame_rows_r, frame_cols_r;
  logic [WIN_W-1:0]   ref_rows_r, guard_rows_r, ref_cols_r, guard_cols_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= RST_FRAME_ROWS;
      frame_cols_r <= RST_FRAME_COLS;
      ref_rows_r   <= RST_REF;
      guard_rows_r <= RST_GUARD;
      ref_cols_r   <= RST_REF;
      guard_cols_r <= RST_GUARD;
      scale_r      <= RST_SCALE;
    end else if (cfg_wr_en) begin
      unique case (cacf_reg_t'(cfg_index))
        REG_FRAME_ROWS: frame_rows_r <= cfg_data[SIZE_W-1:0];
        REG_FRAME_COLS: frame_cols_r <= cfg_data[SIZE_W-1:0];
        REG_REF_ROWS:   ref_rows_r   <= cfg_data[WIN_W-1:0];
        REG_GUARD_ROWS: guard_rows_r <= cfg_data[WIN_W-1:0];
        REG_REF_COLS:   ref_cols_r   <= cfg_data[WIN_W-1:0];
        REG_GUARD_COLS: guard_cols_r <= cfg_data[WIN_W-1:0];
        REG_SCALE:      scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [RW:0] rows_eff;
  logic [CW:0] cols_eff;
  logic [4:0]  gr, gc, rr, rc;
  cacf_win_t   win;

  always_comb begin
    if (frame_rows_r == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (32'(frame_rows_r) > MAX_ROWS) begin
      rows_eff = (RW+1)'(MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(frame_rows_r);
    end
    if (frame_cols_r == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(frame_cols_r) > MAX_COLS) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(frame_cols_r);
    end
    gr = (5'(guard_rows_r) > 5'(H)) ? 5'(H) : 5'(guard_rows_r);
    gc = (5'(guard_cols_r) > 5'(H)) ? 5'(H) : 5'(guard_cols_r);
    rr = (5'(ref_rows_r) > 5'(H) - gr) ? 5'(H) - gr : 5'(ref_rows_r);
    rc = (5'(ref_cols_r) > 5'(H) - gc) ? 5'(H) - gc : 5'(ref_cols_r);
    win.wr = gr + rr;
    win.gr = gr;
    win.wc = gc + rc;
    win.gc = gc;
  end

  // handshake
  logic adv, accept;
  logic skid_v_r, skid_v_nxt;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign accept   = in_valid && adv;

  // position of the arriving cell
  logic [RW-1:0] row_pos_r, row_pos_nxt, r;
  logic [CW-1:0] col_pos_r, col_pos_nxt, c;
  logic [BW-1:0] rowmod_r, rowmod_nxt, rm;
  logic          inframe, interior, is_last;
  logic [RW:0]   r1;
  logic [CW:0]   c1;

  always_comb begin
    r  = in_first_of_frame ? '0 : row_pos_r;
    c  = in_first_of_frame ? '0 : col_pos_r;
    rm = in_first_of_frame ? '0 : rowmod_r;
    inframe  = ({1'b0, r} < rows_eff) && ({1'b0, c} < cols_eff);
    interior = (32'(r) >= 32'({win.wr, 1'b0})) && (32'(c) >= 32'({win.wc, 1'b0}));
    is_last  = ({1'b0, r} == rows_eff - 1'b1) && ({1'b0, c} == cols_eff - 1'b1);
    c1 = {1'b0, c} + 1'b1;
    r1 = {1'b0, r} + 1'b1;
    row_pos_nxt = r;
    col_pos_nxt = CW'(c1);
    rowmod_nxt  = rm;
    if (c1 >= cols_eff) begin
      col_pos_nxt = '0;
      if (r1 >= rows_eff) begin
        row_pos_nxt = '0;
        rowmod_nxt  = '0;
      end else begin
        row_pos_nxt = RW'(r1);
        rowmod_nxt  = (rm == BW'(LINES - 1)) ? '0 : rm + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      rowmod_r  <= '0;
    end else if (accept) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      rowmod_r  <= rowmod_nxt;
    end
  end

  // column sums over the row window
  logic [OW-1:0] col_outer, col_guard;
  logic [SB-1:0] col_center;

  cacf_colsum #(
    .LINES (LINES),
    .DEPTH (MAX_COLS),
    .SB    (SB),
    .BW    (BW),
    .CW    (CW),
    .OW    (OW)
  ) u_colsum (
    .clk        (clk),
    .adv        (adv),
    .wr_en      (accept && inframe),
    .bank       (rm),
    .addr       (c),
    .din        (SB'(in_power)),
    .win        (win),
    .col_outer  (col_outer),
    .col_guard  (col_guard),
    .col_center (col_center)
  );

  // side band through the pipeline
  cacf_flag_t    fl_r [1:NST];
  logic [RW-1:0] tr_r [1:NST];
  logic [CW-1:0] tc_r [1:NST];
  logic [CW-1:0] cp_r [1:3];
  cacf_flag_t    fl_in;

  always_comb begin
    fl_in.vld  = accept && inframe;
    fl_in.res  = accept && inframe && interior;
    fl_in.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        fl_r[s] <= '0;
      end
    end else if (adv) begin
      fl_r[1] <= fl_in;
      for (int s = 2; s <= NST; s++) begin
        fl_r[s] <= fl_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tr_r[1] <= RW'(32'(r) - 32'(win.wr));
      tc_r[1] <= CW'(32'(c) - 32'(win.wc));
      cp_r[1] <= c;
      for (int s = 2; s <= NST; s++) begin
        tr_r[s] <= tr_r[s-1];
        tc_r[s] <= tc_r[s-1];
      end
      for (int s = 2; s <= 3; s++) begin
        cp_r[s] <= cp_r[s-1];
      end
    end
  end

  // column chain: cell i holds the column i+1 places back
  logic          shift;
  logic [OW-1:0] ch_outer  [LINES];
  logic [OW-1:0] ch_guard  [LINES];
  logic [SB-1:0] ch_center [LINES];

  assign shift = adv && fl_r[3].vld;

  for (genvar i = 0; i < LINES; i++) begin : g_chain
    if (i == 0) begin : g_head
      cacf_cell #(.OW(OW), .SB(SB)) u_cell (
        .clk       (clk),
        .shift     (shift),
        .in_outer  (col_outer),
        .in_guard  (col_guard),
        .in_center (col_center),
        .outer     (ch_outer[i]),
        .guard     (ch_guard[i]),
        .center    (ch_center[i])
      );
    end else begin : g_body
      cacf_cell #(.OW(OW), .SB(SB)) u_cell (
        .clk       (clk),
        .shift     (shift),
        .in_outer  (ch_outer[i-1]),
        .in_guard  (ch_guard[i-1]),
        .in_center (ch_center[i-1]),
        .outer     (ch_outer[i]),
        .guard     (ch_guard[i]),
        .center    (ch_center[i])
      );
    end
  end

  // running window sums along the row
  logic [SW-1:0] osum_r, osum_nxt, gsum_r, gsum_nxt;
  logic [SB-1:0] ctr4_r, ctr5_r, ctr6_r, ctr_sel;
  logic [4:0]    gj;
  logic [5:0]    glv;
  logic [OW-1:0] g_in;

  always_comb begin
    gj  = win.wc - win.gc;
    glv = 6'(win.wc) + 6'(win.gc);
    g_in = (gj == '0) ? col_guard : ch_guard[BW'(gj - 1'b1)];
    ctr_sel = (win.wc == '0) ? col_center : ch_center[BW'(win.wc - 1'b1)];
    osum_nxt = ((cp_r[3] == '0) ? '0 : osum_r) + SW'(col_outer);
    if (32'(cp_r[3]) > 32'({win.wc, 1'b0})) begin
      osum_nxt = osum_nxt - SW'(ch_outer[BW'({win.wc, 1'b0})]);
    end
    gsum_nxt = (cp_r[3] == '0) ? '0 : gsum_r;
    if (32'(cp_r[3]) >= 32'(gj)) begin
      gsum_nxt = gsum_nxt + SW'(g_in);
    end
    if (32'(cp_r[3]) > 32'(glv)) begin
      gsum_nxt = gsum_nxt - SW'(ch_guard[BW'(glv)]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osum_r <= '0;
      gsum_r <= '0;
    end else if (shift) begin
      osum_r <= osum_nxt;
      gsum_r <= gsum_nxt;
    end
  end

  // reference sum, split product, compare
  logic [SW-1:0]      rsum5_r, rsum6_r;
  logic [SCALE_W+SH-1:0]      pp_lo_r;
  logic [SCALE_W+SW-SH-1:0]   pp_hi_r;
  logic [PW-1:0]      prod;
  cacf_res_t          pd;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctr4_r  <= ctr_sel;
      rsum5_r <= osum_r - gsum_r;
      ctr5_r  <= ctr4_r;
      pp_lo_r <= scale_r * rsum5_r[SH-1:0];
      pp_hi_r <= scale_r * rsum5_r[SW-1:SH];
      rsum6_r <= rsum5_r;
      ctr6_r  <= ctr5_r;
    end
  end

  always_comb begin
    prod = PW'(pp_lo_r) + (PW'(pp_hi_r) << SH);
    pd.detected = PW'({ctr6_r, FRAC_BITS'(0)}) > prod;
    pd.row      = POS_W'(tr_r[NST]);
    pd.col      = POS_W'(tc_r[NST]);
    pd.ref_sum  = SUM_OUT_W'(rsum6_r);
    pd.last     = fl_r[NST].last;
  end

  // output register with skid stage
  logic      out_v_r, out_v_nxt, push;
  cacf_res_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  always_comb begin
    push       = adv && fl_r[NST].res;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = pd;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = pd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid         = out_v_r;
  assign out_detected      = out_d_r.detected;
  assign out_cell_row      = out_d_r.row;
  assign out_cell_col      = out_d_r.col;
  assign out_ref_sum       = out_d_r.ref_sum;
  assign out_last_of_frame = out_d_r.last;

endmodule
`default_nettype wire

>>> design/cacf_checker.sv
`default_nettype none
`include "cell_averaging_cfar_2d_unit_macros.svh"
module cacf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [32:0] out_ref_sum,
  input wire logic [9:0]  out_cell_row,
  input wire logic [9:0]  out_cell_col
);

  `CACF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CACF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_ref_sum) && $stable(out_cell_row) && $stable(out_cell_col))
  `CACF_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)
  `CACF_ASSERT_NOW(a_drain_on_take, $past(rst_n) && $fell(in_stall),
    $past(out_valid) && !$past(out_stall))

endmodule

bind cell_averaging_cfar_2d_unit cacf_checker u_cacf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_ref_sum  (out_ref_sum),
  .out_cell_row (out_cell_row),
  .out_cell_col (out_cell_col)
);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cacf_pkg::*;

  localparam int LINES = 17;
  localparam int MAXC = 1024;
  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POWER_W-1:0] in_power = '0;
  logic in_first_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_detected;
  logic [POS_W-1:0] out_cell_row;
  logic [POS_W-1:0] out_cell_col;
  logic [SUM_OUT_W-1:0] out_ref_sum;
  logic out_last_of_frame;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  cell_averaging_cfar_2d_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_power(in_power),
    .in_first_of_frame(in_first_of_frame),
    .out_valid(out_valid), .out_stall(out_stall), .out_detected(out_detected),
    .out_cell_row(out_cell_row), .out_cell_col(out_cell_col),
    .out_ref_sum(out_ref_sum), .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // detector state mirrored in the bench
  logic [10:0] n_rows = 11'd1024, n_cols = 11'd1024;
  logic [3:0] r_ref = 4'd4, r_guard = 4'd1, c_ref = 4'd4, c_guard = 4'd1;
  logic [23:0] scale = 24'd262144;
  logic [23:0] cells [LINES*MAXC];
  int unsigned cur_row = 0, cur_col = 0;
  cacf_res_t decisions [$];

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [23:0] cell_val(input int unsigned r, input int unsigned c);
    return cells[(r % LINES) * MAXC + c];
  endfunction

  function automatic void predict_cell(input logic [23:0] pw, input logic first);
    int unsigned rows, cols, gr, gc, rr, rc, wr, wc, r, c, ddr, ddc;
    logic [63:0] sum;
    logic [63:0] cut;
    logic [127:0] prod;
    cacf_res_t d;
    rows = (n_rows == 0) ? 1 : (n_rows > 1024 ? 1024 : n_rows);
    cols = (n_cols == 0) ? 1 : (n_cols > 1024 ? 1024 : n_cols);
    gr = r_guard > 8 ? 8 : r_guard;
    gc = c_guard > 8 ? 8 : c_guard;
    rr = r_ref > 8 - gr ? 8 - gr : r_ref;
    rc = c_ref > 8 - gc ? 8 - gc : c_ref;
    wr = gr + rr;
    wc = gc + rc;
    if (first) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    if (r < rows && c < cols) begin
      cells[(r % LINES) * MAXC + c] = pw;
      if (r >= 2 * wr && c >= 2 * wc) begin
        sum = 0;
        for (int dr = 0; dr <= 2 * wr; dr++)
          for (int dc = 0; dc <= 2 * wc; dc++) begin
            ddr = dr > wr ? dr - wr : wr - dr;
            ddc = dc > wc ? dc - wc : wc - dc;
            if (!(ddr <= gr && ddc <= gc))
              sum += cell_val(r - 2 * wr + dr, c - 2 * wc + dc);
          end
        cut = cell_val(r - wr, c - wc);
        prod = 128'(scale) * 128'(sum);
        d.detected = (128'(cut) << 16) > prod;
        d.row = POS_W'(r - wr);
        d.col = POS_W'(c - wc);
        d.ref_sum = sum[SUM_OUT_W-1:0];
        d.last = (r == rows - 1 && c == cols - 1);
        decisions.push_back(d);
      end
    end
    cur_col = c + 1;
    if (cur_col >= cols) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= rows) cur_row = 0;
    end
  endfunction

  // result side: stall pattern, long hold-off and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decisions.size() == 0) begin
          report($sformatf("unexpected result row %0d col %0d", out_cell_row, out_cell_col));
        end else begin
          cacf_res_t e;
          e = decisions.pop_front();
          if (out_detected !== e.detected || out_cell_row !== e.row ||
              out_cell_col !== e.col || out_ref_sum !== e.ref_sum ||
              out_last_of_frame !== e.last)
            report($sformatf("got %0b r%0d c%0d s%0d l%0b exp %0b r%0d c%0d s%0d l%0b",
              out_detected, out_cell_row, out_cell_col, out_ref_sum, out_last_of_frame,
              e.detected, e.row, e.col, e.ref_sum, e.last));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= LIMIT) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_cell(input logic [23:0] pw, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_power <= pw;
    in_first_of_frame <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cell(pw, first);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decisions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cacf_reg_t idx, input logic [23:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FRAME_ROWS: n_rows = v[10:0];
      REG_FRAME_COLS: n_cols = v[10:0];
      REG_REF_ROWS:   r_ref = v[3:0];
      REG_GUARD_ROWS: r_guard = v[3:0];
      REG_REF_COLS:   c_ref = v[3:0];
      REG_GUARD_COLS: c_guard = v[3:0];
      default:        scale = v;
    endcase
  endtask

  task automatic setup(input int rows, input int cols, input int rr, input int gr,
                       input int rc, input int gc, input int sc);
    write_reg(REG_FRAME_ROWS, 24'(rows));
    write_reg(REG_FRAME_COLS, 24'(cols));
    write_reg(REG_REF_ROWS, 24'(rr));
    write_reg(REG_GUARD_ROWS, 24'(gr));
    write_reg(REG_REF_COLS, 24'(rc));
    write_reg(REG_GUARD_COLS, 24'(gc));
    write_reg(REG_SCALE, 24'(sc));
  endtask

  function automatic logic [23:0] rand_power();
    case ($urandom_range(5))
      0: return 24'hFFFFFF;
      1: return 24'd0;
      2: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_map(input int cells_n, input bit bright);
    for (int i = 0; i < cells_n; i++)
      send_cell(bright ? 24'hFFFFFF : rand_power(), i == 0);
  endtask

  // extremes: all-max map, all-zero map, oversized window clamped, tiny map
  task automatic test_directed();
    setup(3, 3, 0, 1, 0, 1, 24'hFFFFFF);
    send_map(9, 1);
    drain();
    setup(3, 3, 1, 0, 1, 0, 0);
    for (int i = 0; i < 9; i++) send_cell(24'd0, i == 0);
    drain();
    setup(2, 2, 1, 0, 1, 0, 65536);
    send_map(4, 0);
    drain();
    setup(0, 3, 0, 15, 15, 0, 65536);
    send_cell(24'h800000, 1'b1);
    send_cell(24'h000001, 1'b0);
    send_cell(24'h7FFFFF, 1'b0);
    drain();
  endtask

  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int rows, cols, gr, gc, rr, rc;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      gr = $urandom_range(2);
      gc = $urandom_range(2);
      rr = $urandom_range(2);
      rc = $urandom_range(2);
      if ($urandom_range(9) == 0) begin
        gr = $urandom_range(15);
        rr = $urandom_range(15);
      end
      rows = 2 * (gr + rr > 8 ? 8 : gr + rr) + 1 + $urandom_range(4);
      cols = 2 * (gc + rc) + 1 + $urandom_range(6);
      setup(rows, cols, rr, gr, rc, gc, $urandom_range(3) == 0 ? 24'($urandom)
            : 24'($urandom_range(200000)));
      // a map and part of a repeat that restarts with first_of_frame
      send_map(rows * cols, 0);
      for (int i = 0; i < rows * cols; i++)
        send_cell(rand_power(), i == 0 || ($urandom_range(60) == 0));
      sent += 2 * rows * cols;
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering cells
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup(8, 12, 1, 1, 1, 1, 100000);
    hold_cycles = 300;
    send_map(96, 0);
    drain();
  endtask

  // the widest map on columns and the first rows of a tall map
  task automatic test_large();
    setup(1, 1024, 0, 0, 7, 1, 24'hFFFFFF);
    send_map(1024, 0);
    drain();
    setup(1024, 3, 8, 0, 1, 0, 24'd1);
    send_map(20 * 3, 0);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(80, 13, 81);
    test_random(80, 81, 13);
    test_random(80, 0, 0);
    test_backpressure();
    test_large();
    repeat (20) @(posedge clk);
    if (errors == 0 && decisions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
